@@ src/sipd_pkg.sv @@
// Shared types and constants for the status indicator pattern driver.
`timescale 1ns / 1ps

package sipd_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int STATE_W       = 3;
    localparam int STEER_W       = 24;
    localparam int POS_W         = 17;
    localparam int BTN_W         = 8;
    localparam int DPER_W        = 13;
    localparam int BPER_W        = 11;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int OUT_FIELDS_W  = 4 + POS_W + 1 + STATE_W + POS_W + BTN_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // System states.
    localparam logic [STATE_W-1:0] ST_BOOT     = 3'd0;
    localparam logic [STATE_W-1:0] ST_READY    = 3'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 3'd2;
    localparam logic [STATE_W-1:0] ST_DEGRADED = 3'd3;
    localparam logic [STATE_W-1:0] ST_SAFESTOP = 3'd4;
    localparam logic [STATE_W-1:0] ST_FAULT    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZER_ENABLE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_ENABLE   = 4'd3;

    localparam logic [CFG_DATA_W-1:0] DPER_MIN = 16'd200;
    localparam logic [CFG_DATA_W-1:0] DPER_MAX = 16'd5000;
    localparam logic [CFG_DATA_W-1:0] BPER_MIN = 16'd50;
    localparam logic [CFG_DATA_W-1:0] BPER_MAX = 16'd2000;

    localparam logic [DPER_W-1:0] DPER_RESET = 13'd500;
    localparam logic [BPER_W-1:0] BPER_RESET = 11'd250;

    localparam logic signed [STEER_W-1:0] STEER_POS_ONE = 24'sd32768;
    localparam logic signed [STEER_W-1:0] STEER_NEG_ONE = -24'sd32768;
    localparam logic signed [POS_W-1:0]   POS_ONE       = 17'sd32768;
    localparam logic signed [POS_W-1:0]   NEG_ONE       = -17'sd32768;

    typedef struct packed {
        logic builtin;
        logic user;
        logic buzz;
    } pattern_t;

endpackage

@@ src/sipd_pattern.sv @@
// LED and buzzer pattern decode from system state and blink phase.
`timescale 1ns / 1ps

module sipd_pattern (
    input  logic [sipd_pkg::STATE_W-1:0] sys_state,
    input  logic [2:0]                   phase,
    output sipd_pkg::pattern_t           pattern
);
    import sipd_pkg::*;

    always_comb begin
        pattern = '0;
        case (sys_state)
            ST_BOOT: begin
                pattern.builtin = ~phase[0];
            end
            ST_READY: begin
                pattern.builtin = 1'b1;
            end
            ST_RUNNING: begin
                pattern.builtin = (phase[1:0] == 2'd0);
                pattern.user    = 1'b1;
            end
            ST_DEGRADED: begin
                pattern.builtin = ~phase[1];
                pattern.user    = ~phase[0];
            end
            ST_SAFESTOP: begin
                pattern.builtin = ~phase[0];
                pattern.user    = ~phase[0];
                pattern.buzz    = (phase == 3'd0);
            end
            ST_FAULT: begin
                pattern.builtin = ~phase[0];
                pattern.user    = phase[0];
                pattern.buzz    = ~phase[1];
            end
            default: begin
                pattern = '0;
            end
        endcase
    end

endmodule

@@ src/status_indicator_pattern_driver_top.sv @@
// Top level: update sequencer with a shared subtractor for the blink divide and refresh check.
// Items pass one at a time: no new item is taken until the last one has left the sequence, which
// includes the bit-serial divide of the elapsed time by the blink period, one quotient bit a cycle
// through the shared subtractor. An item waits in S_OUT while the output register is still held.
// A finished item waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) clears the start flag, times, sequencer, output valid flag and
// restores the configuration registers to their defaults.
`timescale 1ns / 1ps

module status_indicator_pattern_driver_top #(
    parameter int TIME_BITS = sipd_pkg::TIME_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // now_ms, system_state, steering_in, buttons, zero padding
    input  logic [((TIME_BITS+35+7)/8)*8-1:0]    s_tdata,
    // steering_invalid
    input  logic                                 s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // led_builtin, led_user, buzzer_on, servo_permitted, servo_position,
    // display_refresh, display_state, display_steering, display_buttons, zero padding
    output logic [sipd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sipd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sipd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sipd_pkg::*;

    localparam int CNT_W      = $clog2(TIME_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DIV,
        S_CMP1,
        S_CMP2,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [TIME_BITS-1:0]      start_reg;
    logic [TIME_BITS-1:0]      last_reg;
    logic                      started_reg;
    logic                      first_reg;

    logic [DPER_W-1:0]         dper_reg;
    logic [BPER_W-1:0]         bper_reg;
    logic                      buzz_en_reg;
    logic                      servo_en_reg;

    logic [TIME_BITS-1:0]      now_reg;
    logic [STATE_W-1:0]        sys_state_reg;
    logic signed [STEER_W-1:0] steer_reg;
    logic                      invalid_reg;
    logic [BTN_W-1:0]          btn_reg;

    logic [TIME_BITS-1:0]      work_reg;
    logic [BPER_W-1:0]         rem_reg;
    logic [2:0]                phase_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      refresh_reg;

    logic [OUT_TDATA_W-1:0]    out_reg;
    logic                      out_valid_reg;

    logic [TIME_BITS-1:0]      now_in;
    logic [TIME_BITS-1:0]      sub_a;
    logic [TIME_BITS-1:0]      sub_b;
    logic [TIME_BITS:0]        sub_res;
    logic                      borrow;
    logic [BPER_W:0]           rem_shift;
    logic signed [POS_W-1:0]   steer_clamped;
    logic                      permitted;
    logic                      out_free;
    logic                      show_frame;
    pattern_t                  pattern;

    assign now_in = s_tdata[TIME_BITS-1:0];

    // The one subtractor that the difference, divide and compare steps of the sequence share.
    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow  = sub_res[TIME_BITS];

    assign rem_shift = {rem_reg, work_reg[TIME_BITS-1]};

    always_comb begin
        case (state_reg)
            S_DIV: begin
                sub_a = {{(TIME_BITS-BPER_W-1){1'b0}}, rem_shift};
                sub_b = {{(TIME_BITS-BPER_W){1'b0}}, bper_reg};
            end
            S_CMP1: begin
                sub_a = now_reg;
                sub_b = last_reg;
            end
            S_CMP2: begin
                sub_a = work_reg;
                sub_b = {{(TIME_BITS-DPER_W){1'b0}}, dper_reg};
            end
            default: begin
                sub_a = now_reg;
                sub_b = start_reg;
            end
        endcase
    end

    always_comb begin
        if (invalid_reg) begin
            steer_clamped = '0;
        end else if (steer_reg > STEER_POS_ONE) begin
            steer_clamped = POS_ONE;
        end else if (steer_reg < STEER_NEG_ONE) begin
            steer_clamped = NEG_ONE;
        end else begin
            steer_clamped = steer_reg[POS_W-1:0];
        end
    end

    sipd_pattern u_pattern (
        .sys_state (sys_state_reg),
        .phase     (phase_reg),
        .pattern   (pattern)
    );

    assign permitted  = servo_en_reg && (sys_state_reg == ST_RUNNING);
    assign out_free   = !out_valid_reg || m_tready;
    assign show_frame = refresh_reg && !first_reg;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            start_reg     <= '0;
            last_reg      <= '0;
            started_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            dper_reg      <= DPER_RESET;
            bper_reg      <= BPER_RESET;
            buzz_en_reg   <= 1'b0;
            servo_en_reg  <= 1'b0;
        end else begin
            // The output stage loads a new item itself, so it is left out here.
            if (out_valid_reg && m_tready && (state_reg != S_OUT)) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    REG_DISPLAY_PERIOD: begin
                        if (cfg_data >= DPER_MIN && cfg_data <= DPER_MAX) begin
                            dper_reg <= cfg_data[DPER_W-1:0];
                        end
                    end
                    REG_BLINK_PERIOD: begin
                        if (cfg_data >= BPER_MIN && cfg_data <= BPER_MAX) begin
                            bper_reg <= cfg_data[BPER_W-1:0];
                        end
                    end
                    REG_BUZZER_ENABLE: begin
                        buzz_en_reg <= cfg_data[0];
                    end
                    REG_SERVO_ENABLE: begin
                        servo_en_reg <= cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        now_reg       <= now_in;
                        sys_state_reg <= s_tdata[TIME_BITS+STATE_W-1:TIME_BITS];
                        steer_reg     <= s_tdata[TIME_BITS+STATE_W+STEER_W-1:
                                                 TIME_BITS+STATE_W];
                        btn_reg       <= s_tdata[TIME_BITS+STATE_W+STEER_W+BTN_W-1:
                                                 TIME_BITS+STATE_W+STEER_W];
                        invalid_reg   <= s_tuser;
                        first_reg     <= !started_reg;
                        if (!started_reg) begin
                            start_reg   <= now_in;
                            last_reg    <= now_in;
                            started_reg <= 1'b1;
                        end
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    work_reg  <= sub_res[TIME_BITS-1:0];
                    rem_reg   <= '0;
                    phase_reg <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division; only the three lowest quotient bits are kept.
                    if (!borrow) begin
                        rem_reg <= sub_res[BPER_W-1:0];
                    end else begin
                        rem_reg <= rem_shift[BPER_W-1:0];
                    end
                    phase_reg <= {phase_reg[1:0], !borrow};
                    work_reg  <= {work_reg[TIME_BITS-2:0], 1'b0};
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(TIME_BITS - 1)) begin
                        state_reg <= S_CMP1;
                    end
                end
                S_CMP1: begin
                    work_reg  <= sub_res[TIME_BITS-1:0];
                    state_reg <= S_CMP2;
                end
                S_CMP2: begin
                    refresh_reg <= first_reg || !borrow;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        out_reg <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                                    show_frame ? btn_reg : {BTN_W{1'b0}},
                                    show_frame ? steer_clamped : {POS_W{1'b0}},
                                    show_frame ? sys_state_reg : {STATE_W{1'b0}},
                                    refresh_reg,
                                    permitted ? steer_clamped : {POS_W{1'b0}},
                                    permitted,
                                    pattern.buzz && buzz_en_reg,
                                    pattern.user,
                                    pattern.builtin};
                        out_valid_reg <= 1'b1;
                        if (show_frame) begin
                            last_reg <= now_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The block takes no further item while one is in the sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A result without a refresh carries an empty frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg[4+POS_W] |->
            out_reg[OUT_FIELDS_W-1:5+POS_W] == '0)
        else $error("frame fields set without a display refresh");

    // The servo position is zero whenever the servo is not permitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg[3] |-> out_reg[3+POS_W:4] == '0)
        else $error("servo position driven while not permitted");

    // The blink period never leaves its legal range, so the divide never sees zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bper_reg >= BPER_MIN[BPER_W-1:0] && bper_reg <= BPER_MAX[BPER_W-1:0])
        else $error("blink period out of range");

endmodule
